// ----- rtl/dbgc_pkg.sv -----
package dbgc_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W  = 8;
    localparam int SUM_W     = 15;
    localparam int X_W       = 16;
    localparam int Y_W       = 24;
    localparam int COEF_W    = 32;
    localparam int GAIN_W    = 16;
    localparam int OUT_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Shared multiplier: A carries a coefficient or a sign-extended sum / output,
    // B carries a sample, a history word, the averaging reciprocal or the gain
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Biquad accumulator: five terms aligned to 2^-50 stay below 2^56
    localparam int ACC_W = 58;

    // Feedforward products are in Q1.15 x Q2.30, moved up to the Q4.20 x Q2.30 grid
    localparam int FF_SHIFT = 5;

    // Biquad tap sequencing
    localparam int TAP_W       = 3;
    localparam int NUM_TAPS    = 5;
    localparam int NUM_FF_TAPS = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_B0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_A2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 3'd5;

    // Register reset values
    localparam logic signed [COEF_W-1:0] B0_RST   = 32'sd27355713;
    localparam logic signed [COEF_W-1:0] B1_RST   = 32'sd0;
    localparam logic signed [COEF_W-1:0] B2_RST   = -32'sd27355713;
    localparam logic signed [COEF_W-1:0] A1_RST   = -32'sd2083993000;
    localparam logic signed [COEF_W-1:0] A2_RST   = 32'sd1019031000;
    localparam logic [GAIN_W-1:0]        GAIN_RST = 16'd1024;

    // Operand selection for the shared multiplier
    typedef enum logic [2:0] {
        OP_AVG  = 3'd0,
        OP_B0   = 3'd1,
        OP_B1   = 3'd2,
        OP_B2   = 3'd3,
        OP_A1   = 3'd4,
        OP_A2   = 3'd5,
        OP_GAIN = 3'd6
    } op_t;

    // Sequencer to datapath controls
    typedef struct packed {
        logic mul_en;
        op_t  op;
        logic x_load;
        logic acc_clr;
        logic acc_add;
        logic acc_ff;
        logic y_load;
        logic out_load;
    } ctrl_t;

endpackage

// ----- rtl/decimate_bandpass_gain_clip_unit.sv -----
// Channel   Ports                                     Direction
// input     s_valid s_ready s_raw_sample              in
// result    m_valid m_ready m_audio_out m_clipped     out
// config    cfg_valid cfg_ready cfg_index cfg_data    in
//
// An input byte that does not close a decimation period is taken while s_ready stays high.
// The byte that closes a period holds s_ready low while the single shared 32x25
// multiplier runs the average, the five biquad taps and the gain.
// The result waits in an output register; more bytes are taken meanwhile, but the
// next period's run holds s_ready low until that result is taken.
// Reset (aresetn low, synchronous) restores configuration registers and clears filter history.
// cfg_ready is always high; indexes above the list are dropped.
module decimate_bandpass_gain_clip_unit #(
    parameter int DECIM_FACTOR = 50
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [dbgc_pkg::SAMPLE_W-1:0]          s_raw_sample,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [dbgc_pkg::OUT_W-1:0]      m_audio_out,
    output logic                                   m_clipped,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [dbgc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dbgc_pkg::COEF_W-1:0]            cfg_data
);

    localparam int PHASE_W = (DECIM_FACTOR > 1) ? $clog2(DECIM_FACTOR) : 1;
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(DECIM_FACTOR - 1);

    // Averaging reciprocal, round(2^31 / (255 * DECIM_FACTOR))
    localparam longint AVG_DIV   = 64'sd255 * DECIM_FACTOR;
    localparam longint AVG_RECIP = ((64'sd1 <<< 31) + AVG_DIV / 2) / AVG_DIV;
    localparam logic signed [dbgc_pkg::MUL_B_W-1:0] RECIP_OP =
        dbgc_pkg::MUL_B_W'(AVG_RECIP);

    localparam int PW = dbgc_pkg::PROD_W;
    localparam int AW = dbgc_pkg::ACC_W;

    // Rounding offsets and saturation limits
    localparam logic signed [PW-1:0] ROUND_X = PW'(1) << 15;
    localparam logic signed [PW-1:0] ROUND_V = PW'(1) << 12;
    localparam logic signed [AW-1:0] ROUND_Y = AW'(1) << 29;
    localparam logic signed [PW-1:0] X_MAX   = PW'(2 ** (dbgc_pkg::X_W - 1) - 1);
    localparam logic signed [PW-1:0] X_MIN   = -(PW'(2 ** (dbgc_pkg::X_W - 1)));
    localparam logic signed [AW-1:0] Y_MAX   = AW'(2 ** (dbgc_pkg::Y_W - 1) - 1);
    localparam logic signed [AW-1:0] Y_MIN   = -(AW'(2 ** (dbgc_pkg::Y_W - 1)));
    localparam logic signed [PW-1:0] V_MAX   = PW'(2 ** (dbgc_pkg::OUT_W - 1) - 1);
    localparam logic signed [PW-1:0] V_MIN   = -(PW'(2 ** (dbgc_pkg::OUT_W - 1) - 1));

    dbgc_pkg::ctrl_t ctrl;
    logic            idle;
    logic            in_xfer;
    logic            dump;
    logic            out_free;

    // Configuration registers
    logic signed [dbgc_pkg::COEF_W-1:0] coef_b0_reg, coef_b1_reg, coef_b2_reg;
    logic signed [dbgc_pkg::COEF_W-1:0] coef_a1_reg, coef_a2_reg;
    logic [dbgc_pkg::GAIN_W-1:0]        gain_reg;

    // Decimator
    logic [PHASE_W-1:0]                 phase_reg;
    logic signed [dbgc_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic signed [9:0]                  sample_val;

    // Filter state
    logic signed [dbgc_pkg::X_W-1:0]    x_reg, x_next;
    logic signed [dbgc_pkg::X_W-1:0]    past_in0_reg, past_in1_reg;
    logic signed [dbgc_pkg::Y_W-1:0]    past_out0_reg, past_out1_reg, y_next;
    logic signed [AW-1:0]               acc_reg, acc_term, prod_ext;

    // Multiplier
    logic signed [dbgc_pkg::MUL_A_W-1:0] mul_a;
    logic signed [dbgc_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PW-1:0]                prod;
    logic signed [PW-1:0]                x_round, v_round;
    logic signed [AW-1:0]                y_round;

    // Output register
    logic                               m_valid_reg;
    logic signed [dbgc_pkg::OUT_W-1:0]  audio_reg, audio_next;
    logic                               clip_reg, clip_next;

    assign in_xfer   = s_valid && s_ready;
    assign s_ready   = idle;
    assign cfg_ready = 1'b1;
    assign dump      = (phase_reg == PHASE_LAST);
    assign out_free  = !m_valid_reg || m_ready;

    dbgc_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_xfer  (in_xfer),
        .dump     (dump),
        .out_free (out_free),
        .idle     (idle),
        .ctrl     (ctrl)
    );

    dbgc_mul u_mul (
        .aclk (aclk),
        .en   (ctrl.mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_b0_reg <= dbgc_pkg::B0_RST;
            coef_b1_reg <= dbgc_pkg::B1_RST;
            coef_b2_reg <= dbgc_pkg::B2_RST;
            coef_a1_reg <= dbgc_pkg::A1_RST;
            coef_a2_reg <= dbgc_pkg::A2_RST;
            gain_reg    <= dbgc_pkg::GAIN_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                dbgc_pkg::CFG_B0:   coef_b0_reg <= cfg_data;
                dbgc_pkg::CFG_B1:   coef_b1_reg <= cfg_data;
                dbgc_pkg::CFG_B2:   coef_b2_reg <= cfg_data;
                dbgc_pkg::CFG_A1:   coef_a1_reg <= cfg_data;
                dbgc_pkg::CFG_A2:   coef_a2_reg <= cfg_data;
                dbgc_pkg::CFG_GAIN: gain_reg    <= cfg_data[dbgc_pkg::GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Byte to signed 2b-255, integrate over the period
    assign sample_val = $signed({1'b0, s_raw_sample, 1'b0}) - 10'sd255;
    assign sum_next   = sum_reg + dbgc_pkg::SUM_W'(sample_val);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            sum_reg   <= '0;
        end else if (in_xfer) begin
            sum_reg <= sum_next;
            if (dump) begin
                phase_reg <= '0;
            end else begin
                phase_reg <= phase_reg + 1'b1;
            end
        end else if (ctrl.x_load) begin
            sum_reg <= '0;
        end
    end

    // Operand selection for the shared multiplier
    always_comb begin
        case (ctrl.op)
            dbgc_pkg::OP_AVG: begin
                mul_a = dbgc_pkg::MUL_A_W'(sum_reg);
                mul_b = RECIP_OP;
            end
            dbgc_pkg::OP_B0: begin
                mul_a = coef_b0_reg;
                mul_b = dbgc_pkg::MUL_B_W'(x_reg);
            end
            dbgc_pkg::OP_B1: begin
                mul_a = coef_b1_reg;
                mul_b = dbgc_pkg::MUL_B_W'(past_in0_reg);
            end
            dbgc_pkg::OP_B2: begin
                mul_a = coef_b2_reg;
                mul_b = dbgc_pkg::MUL_B_W'(past_in1_reg);
            end
            dbgc_pkg::OP_A1: begin
                mul_a = coef_a1_reg;
                mul_b = dbgc_pkg::MUL_B_W'(past_out0_reg);
            end
            dbgc_pkg::OP_A2: begin
                mul_a = coef_a2_reg;
                mul_b = dbgc_pkg::MUL_B_W'(past_out1_reg);
            end
            dbgc_pkg::OP_GAIN: begin
                mul_a = dbgc_pkg::MUL_A_W'(past_out0_reg);
                mul_b = $signed({{(dbgc_pkg::MUL_B_W - dbgc_pkg::GAIN_W){1'b0}}, gain_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Average: round to Q1.15 and saturate
    assign x_round = (prod + ROUND_X) >>> 16;
    always_comb begin
        if (x_round > X_MAX) begin
            x_next = X_MAX[dbgc_pkg::X_W-1:0];
        end else if (x_round < X_MIN) begin
            x_next = X_MIN[dbgc_pkg::X_W-1:0];
        end else begin
            x_next = x_round[dbgc_pkg::X_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.x_load) begin
            x_reg <= x_next;
        end
    end

    // Biquad accumulator: feedforward terms shifted up, feedback terms subtracted
    assign prod_ext = {{(AW - PW){prod[PW-1]}}, prod};
    assign acc_term = ctrl.acc_ff ? (prod_ext <<< dbgc_pkg::FF_SHIFT) : -prod_ext;

    always_ff @(posedge aclk) begin
        if (ctrl.acc_clr) begin
            acc_reg <= '0;
        end else if (ctrl.acc_add) begin
            acc_reg <= acc_reg + acc_term;
        end
    end

    // Filter output: round to Q4.20 and saturate
    assign y_round = (acc_reg + ROUND_Y) >>> 30;
    always_comb begin
        if (y_round > Y_MAX) begin
            y_next = Y_MAX[dbgc_pkg::Y_W-1:0];
        end else if (y_round < Y_MIN) begin
            y_next = Y_MIN[dbgc_pkg::Y_W-1:0];
        end else begin
            y_next = y_round[dbgc_pkg::Y_W-1:0];
        end
    end

    // History shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            past_in0_reg  <= '0;
            past_in1_reg  <= '0;
            past_out0_reg <= '0;
            past_out1_reg <= '0;
        end else if (ctrl.y_load) begin
            past_in1_reg  <= past_in0_reg;
            past_in0_reg  <= x_reg;
            past_out1_reg <= past_out0_reg;
            past_out0_reg <= y_next;
        end
    end

    // Gain: round, clip to plus or minus full scale
    assign v_round = (prod + ROUND_V) >>> 13;
    always_comb begin
        if (v_round > V_MAX) begin
            audio_next = V_MAX[dbgc_pkg::OUT_W-1:0];
            clip_next  = 1'b1;
        end else if (v_round < V_MIN) begin
            audio_next = V_MIN[dbgc_pkg::OUT_W-1:0];
            clip_next  = 1'b1;
        end else begin
            audio_next = v_round[dbgc_pkg::OUT_W-1:0];
            clip_next  = 1'b0;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            audio_reg <= audio_next;
            clip_reg  <= clip_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_audio_out = audio_reg;
    assign m_clipped   = clip_reg;

`ifndef SYNTHESIS
    // A period-closing byte blocks further input while the filter runs
    a_dump_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && dump |=> !s_ready)
        else $error("input taken during filter run");

    // A new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.out_load |-> out_free)
        else $error("result register overwritten");

    // Phase counter stays inside the period
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= PHASE_LAST)
        else $error("phase counter out of range");

    // Integrator is empty once the average is taken
    a_sum_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.x_load |=> (sum_reg == '0))
        else $error("integrator not dumped");

    // A clipped result sits at full scale
    a_clip_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clipped |-> (m_audio_out == 16'sd32767 || m_audio_out == -16'sd32767))
        else $error("clipped result not at full scale");
`endif

endmodule

// ----- rtl/dbgc_mul.sv -----
module dbgc_mul (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [dbgc_pkg::MUL_A_W-1:0] a,
    input  logic signed [dbgc_pkg::MUL_B_W-1:0] b,
    output logic signed [dbgc_pkg::PROD_W-1:0]  prod
);

    logic signed [dbgc_pkg::PROD_W-1:0] prod_reg;

    // One signed multiply per cycle while en is high, product registered
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/dbgc_seq.sv -----
module dbgc_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_xfer,
    input  logic            dump,
    input  logic            out_free,
    output logic            idle,
    output dbgc_pkg::ctrl_t ctrl
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_AVG   = 8'b0000_0010,
        ST_XQ    = 8'b0000_0100,
        ST_MAC   = 8'b0000_1000,
        ST_DRAIN = 8'b0001_0000,
        ST_YQ    = 8'b0010_0000,
        ST_GAIN  = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    state_t                       state_reg, state_next;
    logic [dbgc_pkg::TAP_W-1:0]   tap_reg, tap_next;
    logic                         ff_pend_reg, ff_pend_next;

    // State and tap counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tap_reg     <= '0;
            ff_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tap_reg     <= tap_next;
            ff_pend_reg <= ff_pend_next;
        end
    end

    // Next state and controls; a product is accumulated in the cycle after its issue
    always_comb begin
        state_next   = state_reg;
        tap_next     = tap_reg;
        ff_pend_next = 1'b0;
        ctrl         = '0;
        ctrl.op      = dbgc_pkg::OP_AVG;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer && dump) begin
                    state_next = ST_AVG;
                end
            end
            ST_AVG: begin
                ctrl.mul_en = 1'b1;
                ctrl.op     = dbgc_pkg::OP_AVG;
                state_next  = ST_XQ;
            end
            ST_XQ: begin
                ctrl.x_load  = 1'b1;
                ctrl.acc_clr = 1'b1;
                tap_next     = '0;
                state_next   = ST_MAC;
            end
            ST_MAC: begin
                ctrl.mul_en = 1'b1;
                case (tap_reg)
                    3'd0:    ctrl.op = dbgc_pkg::OP_B0;
                    3'd1:    ctrl.op = dbgc_pkg::OP_B1;
                    3'd2:    ctrl.op = dbgc_pkg::OP_B2;
                    3'd3:    ctrl.op = dbgc_pkg::OP_A1;
                    default: ctrl.op = dbgc_pkg::OP_A2;
                endcase
                ctrl.acc_add = (tap_reg != '0);
                ctrl.acc_ff  = ff_pend_reg;
                ff_pend_next = (tap_reg < dbgc_pkg::TAP_W'(dbgc_pkg::NUM_FF_TAPS));
                if (tap_reg == dbgc_pkg::TAP_W'(dbgc_pkg::NUM_TAPS - 1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    tap_next = tap_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                ctrl.acc_add = 1'b1;
                ctrl.acc_ff  = ff_pend_reg;
                state_next   = ST_YQ;
            end
            ST_YQ: begin
                ctrl.y_load = 1'b1;
                state_next  = ST_GAIN;
            end
            ST_GAIN: begin
                ctrl.mul_en = 1'b1;
                ctrl.op     = dbgc_pkg::OP_GAIN;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == ST_IDLE);

endmodule
